/* sv/nrle_pkg.sv */
// shared types and constants of the nibble run-length sprite decoder
package nrle_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned DIM_BITS       = 10;
  localparam int unsigned KEY_BITS       = 4;
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned RUN_BITS       = 4;
  localparam int unsigned INDEX_BITS     = 8;
  localparam int unsigned REG_IDX_BITS   = 2;

  localparam logic [INDEX_BITS-1:0] TRANSPARENT_INDEX = 8'hFF;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_CELL_WIDTH      = 2'd0,
    REG_CELL_HEIGHT     = 2'd1,
    REG_TRANSPARENT_KEY = 2'd2,
    REG_MIRROR          = 2'd3
  } reg_idx_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  // status of one step of the pixel unit
  typedef struct packed {
    logic go;    // a pixel is produced this step
    logic last;  // it is the final pixel of the run
    logic done;  // it completes the last row of the cell
  } step_flags_t;

endpackage

/* sv/nrle_step.sv */
// shared pixel unit: one position advance, wrap and mirror per step
module nrle_step
  import nrle_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] col_i,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [RUN_BITS-1:0]   rem_i,
  input  logic [DIM_BITS-1:0]   cell_width_i,
  input  logic [DIM_BITS-1:0]   cell_height_i,
  input  logic                  mirror_i,
  output logic [COORD_BITS-1:0] col_o,
  output logic [COORD_BITS-1:0] row_o,
  output logic [DIM_BITS-1:0]   pix_col_o,
  output logic [DIM_BITS-1:0]   pix_row_o,
  output step_flags_t           flags_o
);

  localparam int unsigned CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int unsigned EXT_BITS = CMP_BITS + 1;
  localparam logic [DIM_BITS-1:0] OUT_MASK =
    (COORD_BITS >= DIM_BITS) ? {DIM_BITS{1'b1}}
                             : DIM_BITS'((1 << COORD_BITS) - 1);

  logic [EXT_BITS-1:0]   col_e, row_e, cw_e, ch_e;
  logic [COORD_BITS-1:0] col_inc;
  logic [COORD_BITS:0]   row_p1;
  logic [COORD_BITS-1:0] row_inc;
  logic [COORD_BITS-1:0] ch_m;
  logic [CMP_BITS-1:0]   mir_full;
  logic [CMP_BITS-1:0]   col_c, row_c;
  logic                  wrap;
  logic                  done;

  assign col_e = {{(EXT_BITS-COORD_BITS){1'b0}}, col_i};
  assign row_e = {{(EXT_BITS-COORD_BITS){1'b0}}, row_i};
  assign cw_e  = {{(EXT_BITS-DIM_BITS){1'b0}}, cell_width_i};
  assign ch_e  = {{(EXT_BITS-DIM_BITS){1'b0}}, cell_height_i};

  assign col_inc = col_i + 1'b1;
  assign row_p1  = {1'b0, row_i} + 1'b1;
  assign row_inc = row_p1[COORD_BITS-1:0];
  assign ch_m    = ch_e[COORD_BITS-1:0];

  assign wrap = ({{(EXT_BITS-COORD_BITS){1'b0}}, col_inc} >= cw_e);
  assign done = wrap && (EXT_BITS'(row_p1) >= ch_e);

  always_comb begin
    col_o = wrap ? '0 : col_inc;
    if (!wrap) begin
      row_o = row_i;
    end else if (done && ({{(EXT_BITS-COORD_BITS){1'b0}}, row_inc} < ch_e)) begin
      // keep the cell finished when the row counter wraps
      row_o = ch_m;
    end else begin
      row_o = row_inc;
    end
  end

  assign mir_full = cw_e[CMP_BITS-1:0] - col_e[CMP_BITS-1:0] - 1'b1;
  assign col_c    = mirror_i ? mir_full : col_e[CMP_BITS-1:0];
  assign row_c    = row_e[CMP_BITS-1:0];

  assign pix_col_o = col_c[DIM_BITS-1:0] & OUT_MASK;
  assign pix_row_o = row_c[DIM_BITS-1:0] & OUT_MASK;

  assign flags_o.go   = (rem_i != '0) && (row_e < ch_e) && (col_e < cw_e);
  assign flags_o.done = done;
  assign flags_o.last = (rem_i == RUN_BITS'(1)) || done ||
                        ({{(EXT_BITS-COORD_BITS){1'b0}}, col_o} >= cw_e);

endmodule

/* sv/nibble_rle_sprite_decoder.sv */
// top level of the nibble run-length sprite decoder
//
// Each accepted byte is expanded into up to fifteen pixel transactions, one per
// cycle while the output register is free, by a single position unit stepped
// under a two-state sequencer: the byte is taken in the idle state, then every
// following cycle in which the output register is free produces one pixel. A
// byte occupies the block from the cycle it is taken until its last pixel is
// loaded, or until the run state finds no pixel to emit, and in_stall_o is
// high in all of those cycles but the first. The output register lets the last
// pixel wait on a stalled receiver while the next byte is taken.
// The pixel unit advances the column, wraps it into the next row at the cell
// width, reflects the column in mirror mode and flags the cell end. Registers
// are written over a separate valid/ready port which is always ready.
module nibble_rle_sprite_decoder
  import nrle_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [REG_IDX_BITS-1:0] cfg_index_i,
  input  logic [DIM_BITS-1:0]     cfg_data_i,
  // coded bytes
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [BYTE_BITS-1:0]    rle_byte_i,
  input  logic                    start_cell_i,
  // pixels
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DIM_BITS-1:0]     pixel_column_o,
  output logic [DIM_BITS-1:0]     pixel_row_o,
  output logic [INDEX_BITS-1:0]   pixel_index_o,
  output logic                    run_last_o,
  output logic                    cell_done_o
);

  // configuration registers
  logic [DIM_BITS-1:0] cell_width_q, cell_height_q;
  logic [KEY_BITS-1:0] key_q;
  logic                mirror_q;

  // decode state
  seq_state_e              state_q, state_d;
  logic [COORD_BITS-1:0]   col_q, col_d, row_q, row_d;
  logic [RUN_BITS-1:0]     rem_q, rem_d;
  logic [INDEX_BITS-1:0]   index_q, index_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [DIM_BITS-1:0]     pix_col_q, pix_col_d, pix_row_q, pix_row_d;
  logic [INDEX_BITS-1:0]   pix_idx_q, pix_idx_d;
  logic                    last_q, last_d, done_q, done_d;

  // pixel unit
  logic [COORD_BITS-1:0]   step_col, step_row;
  logic [DIM_BITS-1:0]     step_pix_col, step_pix_row;
  step_flags_t             step_flags;

  logic                    in_accept;
  logic                    out_free;
  logic [KEY_BITS-1:0]     colour;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q  <= '0;
      cell_height_q <= '0;
      key_q         <= '0;
      mirror_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_CELL_WIDTH:      cell_width_q  <= cfg_data_i;
        REG_CELL_HEIGHT:     cell_height_q <= cfg_data_i;
        REG_TRANSPARENT_KEY: key_q         <= cfg_data_i[KEY_BITS-1:0];
        REG_MIRROR:          mirror_q      <= cfg_data_i[0];
        default:             ;
      endcase
    end
  end

  nrle_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .col_i        (col_q),
    .row_i        (row_q),
    .rem_i        (rem_q),
    .cell_width_i (cell_width_q),
    .cell_height_i(cell_height_q),
    .mirror_i     (mirror_q),
    .col_o        (step_col),
    .row_o        (step_row),
    .pix_col_o    (step_pix_col),
    .pix_row_o    (step_pix_row),
    .flags_o      (step_flags)
  );

  assign in_stall_o = (state_q != SEQ_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign colour     = rle_byte_i[KEY_BITS-1:0];

  // sequencer: take a byte, then one pixel per free output slot
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    rem_d       = rem_q;
    index_d     = index_q;
    out_valid_d = out_valid_q && out_stall_i;
    pix_col_d   = pix_col_q;
    pix_row_d   = pix_row_q;
    pix_idx_d   = pix_idx_q;
    last_d      = last_q;
    done_d      = done_q;

    unique case (state_q)
      SEQ_IDLE: begin
        if (in_accept) begin
          if (start_cell_i) begin
            col_d = '0;
            row_d = '0;
          end
          rem_d   = rle_byte_i[BYTE_BITS-1:KEY_BITS];
          index_d = (colour == key_q) ? TRANSPARENT_INDEX
                                      : {{(INDEX_BITS-KEY_BITS){1'b0}}, colour};
          state_d = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (out_free) begin
          if (step_flags.go) begin
            out_valid_d = 1'b1;
            pix_col_d   = step_pix_col;
            pix_row_d   = step_pix_row;
            pix_idx_d   = index_q;
            last_d      = step_flags.last;
            done_d      = step_flags.done;
            col_d       = step_col;
            row_d       = step_row;
            rem_d       = rem_q - 1'b1;
            if (step_flags.last) begin
              state_d = SEQ_IDLE;
            end
          end else begin
            // zero repeat, finished cell or column past the width
            state_d = SEQ_IDLE;
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    index_q   <= index_d;
    pix_col_q <= pix_col_d;
    pix_row_q <= pix_row_d;
    pix_idx_q <= pix_idx_d;
    last_q    <= last_d;
    done_q    <= done_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_column_o = pix_col_q;
  assign pixel_row_o    = pix_row_q;
  assign pixel_index_o  = pix_idx_q;
  assign run_last_o     = last_q;
  assign cell_done_o    = done_q;

  // a pixel that ends the cell also ends its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_done_o |-> run_last_o)
    else $error("cell_done without run_last");

  // a taken byte blocks input in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after transaction");

  // a new pixel is only loaded while a run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == SEQ_RUN))
    else $error("pixel produced outside a run");

endmodule
